// ===== design/iibh_pkg.sv =====
package iibh_pkg;

    localparam int CTR_W = 12;   // holds any pixel index up to 4095
    localparam int QW    = 14;   // signed query coordinate width
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BOX    = 2'd1;
    localparam logic [1:0] OP_HAAR_X = 2'd2;
    localparam logic [1:0] OP_HAAR_Y = 2'd3;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    localparam logic [23:0] GREY_R = 24'd19589;
    localparam logic [23:0] GREY_G = 24'd38470;
    localparam logic [23:0] GREY_B = 24'd7471;

    typedef enum logic {K_LOAD, K_QUERY} t_kind;

    typedef struct packed {
        logic [CTR_W:0] w;
        logic [CTR_W:0] h;
    } t_dims;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        op;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [CTR_W-1:0]  x;
        logic [CTR_W-1:0]  y;
        logic signed [9:0] row;
        logic signed [9:0] col;
        logic [9:0]        rows;
        logic [9:0]        cols;
        logic [9:0]        size;
    } t_cmd;

    function automatic logic [CTR_W:0] eff_dim(input logic [8:0] v, input int mx);
        logic [CTR_W:0] m;
        m = (CTR_W+1)'(mx);
        if (v == 9'd0) return (CTR_W+1)'(1);
        if ((CTR_W+1)'(v) > m) return m;
        return (CTR_W+1)'(v);
    endfunction

endpackage

// ===== design/iibh_ram.sv =====
module iibh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/iibh_fifo.sv =====
module iibh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            if (w_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ===== design/iibh_front.sv =====
module iibh_front import iibh_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data,
    input  logic              i_push,
    input  logic              i_q_full,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_pixel_red,
    input  logic [7:0]        i_pixel_green,
    input  logic [7:0]        i_pixel_blue,
    input  logic signed [9:0] i_query_row,
    input  logic signed [9:0] i_query_col,
    input  logic [9:0]        i_query_rows,
    input  logic [9:0]        i_query_cols,
    input  logic [9:0]        i_haar_size,
    output logic              o_q_push,
    output t_cmd              o_cmd,
    output t_dims             o_dims
);
    logic [8:0]       r_width, r_height;
    logic [CTR_W-1:0] r_x, r_y;
    logic             r_done;
    logic             w_accept, w_load, w_restart;
    logic [CTR_W:0]   w_x1, w_y1;

    assign o_dims.w  = eff_dim(r_width, MAX_WIDTH);
    assign o_dims.h  = eff_dim(r_height, MAX_HEIGHT);
    assign w_accept  = i_push && !i_q_full;
    assign w_load    = (i_operation == OP_LOAD);
    assign w_restart = i_cfg_we && (i_cfg_index[1] == 1'b0);
    assign w_x1      = {1'b0, r_x} + 1'b1;
    assign w_y1      = {1'b0, r_y} + 1'b1;

    // drop queries that arrive before a whole frame is in the store
    assign o_q_push    = w_accept && (w_load || r_done);
    assign o_cmd.kind  = w_load ? K_LOAD : K_QUERY;
    assign o_cmd.op    = i_operation;
    assign o_cmd.red   = i_pixel_red;
    assign o_cmd.green = i_pixel_green;
    assign o_cmd.blue  = i_pixel_blue;
    assign o_cmd.x     = r_x;
    assign o_cmd.y     = r_y;
    assign o_cmd.row   = i_query_row;
    assign o_cmd.col   = i_query_col;
    assign o_cmd.rows  = i_query_rows;
    assign o_cmd.cols  = i_query_cols;
    assign o_cmd.size  = i_haar_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_x      <= '0;
            r_y      <= '0;
            r_done   <= 1'b0;
        end else if (w_restart) begin
            if (i_cfg_index[0] == CFG_WIDTH) r_width <= i_cfg_data;
            else                             r_height <= i_cfg_data;
            r_x    <= '0;
            r_y    <= '0;
            r_done <= 1'b0;
        end else if (w_accept && w_load) begin
            r_done <= 1'b0;
            if (w_x1 >= o_dims.w) begin
                r_x <= '0;
                if (w_y1 >= o_dims.h) begin
                    r_y    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_y <= w_y1[CTR_W-1:0];
                end
            end else begin
                r_x <= w_x1[CTR_W-1:0];
            end
        end
    end
endmodule

// ===== design/iibh_back.sv =====
module iibh_back import iibh_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_cmd               i_cmd,
    output logic               o_q_pop,
    input  t_dims              i_dims,
    input  logic               i_res_full,
    output logic               o_res_push,
    output logic signed [32:0] o_res
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_LD_RD, S_LD_WR, S_Q_SET, S_Q_RD, S_Q_ACC, S_Q_FIN, S_Q_OUT
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [15:0]           r_grey;
    logic [23:0]           r_rsum;
    logic                  r_box, r_cv;
    logic [1:0]            r_j;
    logic signed [QW-1:0]  r_r1, r_c1, r_r2, r_c2;
    logic signed [34:0]    r_acc;
    logic signed [32:0]    r_box0, r_res;

    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [31:0]           w_wdata, w_rdata;
    logic [23:0]           w_rsum_n, w_grey_sum;
    logic signed [QW-1:0]  w_h, w_bro, w_bco, w_brs, w_bcs;
    logic signed [QW-1:0]  w_hh, w_ww, w_cr, w_cc;
    logic signed [34:0]    w_term;
    logic signed [32:0]    w_clamp;
    logic                  w_cv;

    iibh_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    function automatic logic signed [QW-1:0] smin(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    assign w_grey_sum = GREY_R * 24'(r_cmd.red) + GREY_G * 24'(r_cmd.green)
                      + GREY_B * 24'(r_cmd.blue);
    assign w_rsum_n   = ((r_cmd.x == '0) ? 24'd0 : r_rsum) + 24'(r_grey);
    assign w_we       = (r_state == S_LD_WR);
    assign w_waddr    = AW'(32'(r_cmd.y) * 32'(MAX_WIDTH) + 32'(r_cmd.x));
    assign w_wdata    = 32'(w_rsum_n) + ((r_cmd.y != '0) ? w_rdata : 32'd0);

    // box origin and extent for the box now being summed
    assign w_h  = QW'(signed'({1'b0, r_cmd.size[9:1]}));
    assign w_hh = QW'(signed'({1'b0, i_dims.h}));
    assign w_ww = QW'(signed'({1'b0, i_dims.w}));
    always_comb begin
        w_bro = QW'(r_cmd.row);
        w_bco = QW'(r_cmd.col);
        w_brs = QW'(signed'({1'b0, r_cmd.rows}));
        w_bcs = QW'(signed'({1'b0, r_cmd.cols}));
        case (r_cmd.op)
            OP_HAAR_X: begin
                w_bro = QW'(r_cmd.row) - w_h;
                w_bco = r_box ? QW'(r_cmd.col) - w_h : QW'(r_cmd.col);
                w_brs = QW'(signed'({1'b0, r_cmd.size}));
                w_bcs = w_h;
            end
            OP_HAAR_Y: begin
                w_bro = r_box ? QW'(r_cmd.row) - w_h : QW'(r_cmd.row);
                w_bco = QW'(r_cmd.col) - w_h;
                w_brs = w_h;
                w_bcs = QW'(signed'({1'b0, r_cmd.size}));
            end
            default: ;
        endcase
    end

    // corner order: A(+), B(-), C(-), D(+)
    assign w_cr = r_j[1] ? r_r2 : r_r1;
    assign w_cc = r_j[0] ? r_c2 : r_c1;
    assign w_cv = (w_cr >= 0) && (w_cc >= 0);
    always_comb begin
        w_raddr = AW'(32'(w_cr[CTR_W-1:0]) * 32'(MAX_WIDTH) + 32'(w_cc[CTR_W-1:0]));
        if (r_state == S_LD_RD)
            w_raddr = AW'(32'(r_cmd.y - 1'b1) * 32'(MAX_WIDTH) + 32'(r_cmd.x));
    end
    assign w_term  = r_cv ? 35'(w_rdata) : 35'sd0;
    always_comb begin
        if (r_acc < 0)                        w_clamp = 33'sd0;
        else if (r_acc > 35'sh0_FFFF_FFFF)    w_clamp = 33'sh0_FFFF_FFFF;
        else                                  w_clamp = r_acc[32:0];
    end

    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_res_push = (r_state == S_Q_OUT);
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsum  <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (!i_q_empty) begin
                    r_cmd   <= i_cmd;
                    r_box   <= 1'b0;
                    r_state <= (i_cmd.kind == K_LOAD) ? S_LD_RD : S_Q_SET;
                end
                S_LD_RD: begin
                    r_grey  <= w_grey_sum[23:8];
                    r_state <= S_LD_WR;
                end
                S_LD_WR: begin
                    r_rsum  <= w_rsum_n;
                    r_state <= S_IDLE;
                end
                S_Q_SET: begin
                    r_r1    <= smin(w_bro, w_hh) - 1'b1;
                    r_c1    <= smin(w_bco, w_ww) - 1'b1;
                    r_r2    <= smin(w_bro + w_brs, w_hh) - 1'b1;
                    r_c2    <= smin(w_bco + w_bcs, w_ww) - 1'b1;
                    r_j     <= 2'd0;
                    r_acc   <= '0;
                    r_state <= S_Q_RD;
                end
                S_Q_RD: begin
                    r_cv    <= w_cv;
                    r_state <= S_Q_ACC;
                end
                S_Q_ACC: begin
                    r_acc   <= (r_j == 2'd0 || r_j == 2'd3) ? r_acc + w_term : r_acc - w_term;
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j == 2'd3) ? S_Q_FIN : S_Q_RD;
                end
                S_Q_FIN: begin
                    if (r_box) begin
                        r_res   <= r_box0 - w_clamp;
                        r_state <= S_Q_OUT;
                    end else if (r_cmd.op == OP_BOX) begin
                        r_res   <= w_clamp;
                        r_state <= S_Q_OUT;
                    end else begin
                        r_box0  <= w_clamp;
                        r_box   <= 1'b1;
                        r_state <= S_Q_SET;
                    end
                end
                S_Q_OUT: if (!i_res_full) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/integral_image_box_haar.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// items    | push / full         | i_operation, i_pixel_*, i_query_*, i_haar_size
// results  | empty / pop         | o_response (33-bit signed)
// config   | i_cfg_we, no wait   | i_cfg_index, i_cfg_data (width, height)
//
// In the back a load has a read and a write state; a box query has set-up,
// four corner read/accumulate pairs, finish and output; a Haar query sums two
// boxes, then outputs; every corner uses the store's single read port.
// Reset is synchronous, active low; the store is not cleared (it is always
// written before it is read). A two-entry command queue parts the front from
// the back, and a two-entry result queue holds answers while pop is low; the
// back holds its output cycle while that queue is full.
module integral_image_box_haar import iibh_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_pixel_red,
    input  logic [7:0]         i_pixel_green,
    input  logic [7:0]         i_pixel_blue,
    input  logic signed [9:0]  i_query_row,
    input  logic signed [9:0]  i_query_col,
    input  logic [9:0]         i_query_rows,
    input  logic [9:0]         i_query_cols,
    input  logic [9:0]         i_haar_size,
    output logic               empty,
    input  logic               pop,
    output logic signed [32:0] o_response,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data
);
    t_cmd               w_cmd_in, w_cmd_out;
    t_dims              w_dims;
    logic               w_q_push, w_q_full, w_q_empty, w_q_pop;
    logic               w_res_push, w_res_full;
    logic signed [32:0] w_res;

    assign full = w_q_full;

    // front: track raster position and frame completion, classify each item
    iibh_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_push(push), .i_q_full(w_q_full),
        .i_operation, .i_pixel_red, .i_pixel_green, .i_pixel_blue,
        .i_query_row, .i_query_col, .i_query_rows, .i_query_cols, .i_haar_size,
        .o_q_push(w_q_push), .o_cmd(w_cmd_in), .o_dims(w_dims)
    );

    // command queue: transfer classified work to the back
    iibh_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(2)) u_cmd_q (
        .i_clk, .i_rst_n,
        .i_push(w_q_push), .i_data(w_cmd_in), .o_full(w_q_full),
        .i_pop(w_q_pop), .o_empty(w_q_empty), .o_data(w_cmd_out)
    );

    // back: build store entries and sum box corners
    iibh_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk, .i_rst_n,
        .i_q_empty(w_q_empty), .i_cmd(w_cmd_out), .o_q_pop(w_q_pop),
        .i_dims(w_dims),
        .i_res_full(w_res_full), .o_res_push(w_res_push), .o_res(w_res)
    );

    // result queue: hold answers until the consumer takes the transfer
    iibh_fifo #(.WIDTH(33), .DEPTH(2)) u_res_q (
        .i_clk, .i_rst_n,
        .i_push(w_res_push), .i_data(w_res), .o_full(w_res_full),
        .i_pop(pop), .o_empty(empty), .o_data(o_response)
    );
endmodule

// ===== bench/integral_image_box_haar_test.sv =====
module integral_image_box_haar_test;
    import iibh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_W = 256;
    localparam int STORE_H = 256;

    // One input transfer as the sender sees it.
    typedef struct {
        logic [1:0]        op;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic signed [9:0] row;
        logic signed [9:0] col;
        logic [9:0]        rows;
        logic [9:0]        cols;
        logic [9:0]        size;
    } t_item;

    // Integral-image predictor plus the queue of responses still owed by the block.
    class integral_scoreboard;
        bit [31:0]         sums [STORE_W*STORE_H];
        bit [23:0]         row_acc;
        int unsigned       at_x;
        int unsigned       at_y;
        bit                frame_ready;
        bit [8:0]          width_reg;
        bit [8:0]          height_reg;
        logic signed [32:0] owed [$];
        int                errors;
        int                answered;
        int                loads;

        function void clear();
            width_reg   = 9'd256;
            height_reg  = 9'd256;
            restart();
        endfunction

        function void restart();
            row_acc     = '0;
            at_x        = 0;
            at_y        = 0;
            frame_ready = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [8:0] val);
            if (idx == 2'(CFG_WIDTH)) begin
                width_reg = val;
            end else if (idx == 2'(CFG_HEIGHT)) begin
                height_reg = val;
            end else begin
                return;
            end
            restart();
        endfunction

        function int clamp_dim(bit [8:0] v, int mx);
            if (v == 0) return 1;
            if (v > mx) return mx;
            return v;
        endfunction

        function int eff_w();
            return clamp_dim(width_reg, STORE_W);
        endfunction

        function int eff_h();
            return clamp_dim(height_reg, STORE_H);
        endfunction

        function longint corner(int r, int c);
            if (r < 0 || c < 0) return 0;
            return longint'(sums[r*STORE_W + c]);
        endfunction

        function longint box(int row, int col, int rows, int cols);
            int     h;
            int     w;
            int     r1;
            int     c1;
            int     r2;
            int     c2;
            longint s;
            h  = eff_h();
            w  = eff_w();
            r1 = ((row < h) ? row : h) - 1;
            c1 = ((col < w) ? col : w) - 1;
            r2 = ((row + rows < h) ? row + rows : h) - 1;
            c2 = ((col + cols < w) ? col + cols : w) - 1;
            s = corner(r1, c1) - corner(r1, c2) - corner(r2, c1) + corner(r2, c2);
            if (s < 0) s = 0;
            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
            return s;
        endfunction

        // Fold one accepted transfer into the model; queue a response if one is due.
        function void note_item(t_item it);
            int unsigned grey;
            bit [31:0]   v;
            int          row;
            int          col;
            int          half;
            int          size;
            longint      resp;
            if (it.op == OP_LOAD) begin
                loads++;
                grey = (19589 * it.red + 38470 * it.green + 7471 * it.blue) >> 8;
                frame_ready = 1'b0;
                if (at_x == 0) row_acc = '0;
                row_acc = row_acc + 24'(grey);
                v = 32'(row_acc);
                if (at_y > 0) v += sums[(at_y-1)*STORE_W + at_x];
                sums[at_y*STORE_W + at_x] = v;
                at_x++;
                if (at_x >= eff_w()) begin
                    at_x = 0;
                    at_y++;
                    if (at_y >= eff_h()) begin
                        at_y = 0;
                        frame_ready = 1'b1;
                    end
                end
                return;
            end
            if (!frame_ready) return;
            row  = it.row;
            col  = it.col;
            size = it.size;
            half = size >> 1;
            if (it.op == OP_BOX) begin
                resp = box(row, col, it.rows, it.cols);
            end else if (it.op == OP_HAAR_X) begin
                resp = box(row - half, col, size, half) - box(row - half, col - half, size, half);
            end else begin
                resp = box(row, col - half, half, size) - box(row - half, col - half, half, size);
            end
            owed.push_back(33'(resp));
        endfunction

        function void check(logic signed [32:0] got);
            logic signed [32:0] want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response %0d", got);
                return;
            end
            want = owed.pop_front();
            answered++;
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("response mismatch: expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [1:0]         i_operation;
    logic [7:0]         i_pixel_red;
    logic [7:0]         i_pixel_green;
    logic [7:0]         i_pixel_blue;
    logic signed [9:0]  i_query_row;
    logic signed [9:0]  i_query_col;
    logic [9:0]         i_query_rows;
    logic [9:0]         i_query_cols;
    logic [9:0]         i_haar_size;
    logic               empty;
    logic               pop;
    logic signed [32:0] o_response;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [8:0]         i_cfg_data;

    integral_scoreboard sb;
    logic               hold_off;     // receiver long stall, driven by its own process
    int                 sent;
    int                 cfg_writes;
    int                 pop_gap;

    integral_image_box_haar i_dut (.*);

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and hold it until the block takes the transfer.
    task automatic send_item(t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_operation   <= it.op;
        i_pixel_red   <= it.red;
        i_pixel_green <= it.green;
        i_pixel_blue  <= it.blue;
        i_query_row   <= it.row;
        i_query_col   <= it.col;
        i_query_rows  <= it.rows;
        i_query_cols  <= it.cols;
        i_haar_size   <= it.size;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_item(it);
        sent++;
    endtask

    // Drop push, drain every owed response, let any silent query finish, then write.
    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_item it;
        it = '{OP_LOAD, r, g, b, 10'($urandom), 10'($urandom), 10'($urandom),
               10'($urandom), 10'($urandom)};
        send_item(it);
    endtask

    task automatic send_query(logic [1:0] op, int row, int col, int rows, int cols, int size);
        t_item it;
        it = '{op, 8'($urandom), 8'($urandom), 8'($urandom), 10'(row), 10'(col),
               10'(rows), 10'(cols), 10'(size)};
        send_item(it);
    endtask

    // Load a frame of random colors; a few pixels at the color extremes.
    task automatic load_frame(int count);
        int p;
        for (int k = 0; k < count; k++) begin
            p = $urandom_range(0, 9);
            if (p == 0) send_pixel(8'hFF, 8'hFF, 8'hFF);
            else if (p == 1) send_pixel(8'h00, 8'h00, 8'h00);
            else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Queries mostly near the frame, the rest with fully random fields.
    task automatic random_query();
        int w;
        int h;
        int op;
        w  = sb.eff_w();
        h  = sb.eff_h();
        op = $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) begin
            send_query(2'(op), $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            send_query(2'(op), $urandom_range(0, h + 4) - 2, $urandom_range(0, w + 4) - 2,
                       $urandom_range(0, h + 2), $urandom_range(0, w + 2),
                       $urandom_range(0, 2 * ((w > h) ? w : h) + 2));
        end
    endtask

    // Receiver: accept a transfer when pop meets a non-empty queue, then pick the next pop.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop     <= 1'b0;
            pop_gap <= 0;
        end else begin
            if (pop && !empty) sb.check(o_response);
            if (hold_off) begin
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop     <= 1'b0;
                pop_gap <= pop_gap - 1;
            end else begin
                pop     <= 1'b1;
                pop_gap <= pick_gap();
            end
        end
    end

    // Long receiver stall early in the query burst on the finished row, while the
    // sender keeps offering queries: fills the queues.
    initial begin
        hold_off = 1'b0;
        wait (sb != null && sb.answered >= 10);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog.
    initial begin
        #(12ns * 2_500_000);
        $display("integral_image_box_haar test failed");
        $finish;
    end

    initial begin
        int w_pick;
        int weff;
        int heff;
        int hmax;
        sb = new;
        sb.clear();
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_operation   = OP_LOAD;
        i_pixel_red   = '0;
        i_pixel_green = '0;
        i_pixel_blue  = '0;
        i_query_row   = '0;
        i_query_col   = '0;
        i_query_rows  = '0;
        i_query_cols  = '0;
        i_haar_size   = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        sent          = 0;
        cfg_writes    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Queries before any frame has loaded: no answer owed.
        send_query(OP_BOX, 0, 0, 1, 1, 0);
        send_query(OP_HAAR_X, 1, 1, 0, 0, 2);

        // Zero registers act as a one-pixel frame.
        write_reg(2'(CFG_WIDTH), 9'd0);
        write_reg(2'(CFG_HEIGHT), 9'd0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_query(OP_BOX, 0, 0, 1, 1, 0);
        send_query(OP_BOX, -512, -512, 1023, 1023, 0);
        send_query(OP_BOX, 511, 511, 0, 0, 0);
        send_query(OP_HAAR_X, 0, 0, 0, 0, 1023);
        send_query(OP_HAAR_Y, 0, 0, 0, 0, 1);
        send_query(OP_HAAR_Y, -1, -1, 0, 0, 0);

        // Oversized width acts as the maximum: one 256-pixel row.
        write_reg(2'(CFG_WIDTH), 9'd511);
        write_reg(2'(CFG_HEIGHT), 9'd1);
        load_frame(256);
        send_query(OP_BOX, 0, 0, 1, 256, 0);
        send_query(OP_HAAR_X, 0, 128, 0, 0, 256);

        // A load after a finished frame starts a new one and silences queries.
        send_pixel(8'h12, 8'h34, 8'h56);
        send_query(OP_BOX, 0, 0, 1, 1, 0);
        load_frame(255);

        // Burst of queries on the finished row.
        for (int k = 0; k < 20; k++) random_query();

        // Random phases: new dimensions, one or two frames (sometimes with early queries), each followed by queries.
        while (sent < 1300) begin
            w_pick = $urandom_range(0, 9);
            if (w_pick < 7) begin
                if ($urandom_range(0, 1)) write_reg(2'(CFG_WIDTH), 9'($urandom_range(1, 16)));
                else write_reg(2'(CFG_WIDTH), 9'($urandom));
            end
            weff = sb.eff_w();
            hmax = 512 / weff;
            if (hmax < 1) hmax = 1;
            if (hmax > 16) hmax = 16;
            if (w_pick != 3 || sb.eff_h() * weff > 600) begin
                if ($urandom_range(0, 7) == 0 && weff <= 2)
                    write_reg(2'(CFG_HEIGHT), 9'($urandom_range(200, 511)));
                else
                    write_reg(2'(CFG_HEIGHT), 9'($urandom_range(0, hmax)));
            end
            weff = sb.eff_w();
            heff = sb.eff_h();
            for (int f = 0; f < 1 + ($urandom_range(0, 4) == 0); f++) begin
                if ($urandom_range(0, 5) == 0 && weff * heff > 1) begin
                    load_frame(weff * heff / 2);
                    repeat (2) random_query();
                    load_frame(weff * heff - weff * heff / 2);
                end else begin
                    load_frame(weff * heff);
                end
                repeat ($urandom_range(8, 30)) random_query();
            end
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d pixel loads, %0d answered queries, %0d register writes",
                 sb.loads, sb.answered, cfg_writes);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("integral_image_box_haar test passed");
        end else begin
            $display("integral_image_box_haar test failed");
        end
        $finish;
    end

endmodule
